// ===== sv/scfr_pkg.sv =====
package scfr_pkg;

    localparam int MAX_FRAME_BYTES = 256;

    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [9:0] MAX_BYTES_W = 10'(MAX_FRAME_BYTES);
    localparam logic [9:0] HDR_TRL_BYTES = 10'd5;

    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_GOOD    = 3'd1;
    localparam logic [2:0] ST_FRAMING = 3'd2;
    localparam logic [2:0] ST_CRC     = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [2:0] OP_IGNORE  = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_PEND    = 3'd2;
    localparam logic [2:0] OP_FRAMING = 3'd3;
    localparam logic [2:0] OP_PAYLOAD = 3'd4;
    localparam logic [2:0] OP_CRCB    = 3'd5;
    localparam logic [2:0] OP_END     = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       start_frame;
        logic       chunk_end;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [7:0] payload_index;
        logic [7:0] payload_length;
    } t_out;

    typedef struct packed {
        logic [2:0] code;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] length;
    } t_op;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== sv/scfr_front.sv =====
module scfr_front
    import scfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    input  logic i_full,
    output logic o_push,
    output t_op  o_op
);

    logic [8:0] r_cnt, n_cnt;
    logic [7:0] r_len, n_len;
    logic       r_done, n_done;
    logic [8:0] eff_cnt;
    logic [7:0] eff_len;
    logic       eff_done;
    logic [9:0] nxt;
    logic [9:0] len_w;
    logic       accept;
    t_op        op;

    assign accept = i_in_valid && !i_full;

    always_comb begin
        eff_cnt  = i_in_data.start_frame ? 9'd0 : r_cnt;
        eff_len  = i_in_data.start_frame ? 8'd0 : r_len;
        eff_done = i_in_data.start_frame ? 1'b0 : r_done;
        nxt      = {1'b0, eff_cnt} + 10'd1;
        len_w    = {2'b00, eff_len};
        n_cnt    = eff_cnt;
        n_len    = eff_len;
        n_done   = eff_done;
        op.code  = OP_PEND;
        op.data  = i_in_data.rx_byte;
        op.index = 8'd0;
        if (eff_done) begin
            op.code = OP_IGNORE;
        end else if (eff_cnt == 9'd0) begin
            if (i_in_data.rx_byte != STX_BYTE) begin
                op.code = OP_FRAMING;
                n_done  = 1'b1;
            end else begin
                op.code = OP_LOAD;
                n_cnt   = 9'd1;
                n_len   = 8'd0;
            end
        end else if ({1'b0, eff_cnt} >= MAX_BYTES_W) begin
            op.code = OP_FRAMING;
            n_done  = 1'b1;
        end else begin
            n_cnt = nxt[8:0];
            if (nxt == 10'd2) begin
                n_len = i_in_data.rx_byte;
                if (i_in_data.rx_byte == 8'd0
                    || {2'b00, i_in_data.rx_byte} + HDR_TRL_BYTES > MAX_BYTES_W) begin
                    op.code = OP_FRAMING;
                    n_done  = 1'b1;
                end
            end else if (nxt <= len_w + 10'd2) begin
                op.code  = OP_PAYLOAD;
                op.index = 8'(nxt - 10'd3);
            end else if (nxt <= len_w + 10'd4) begin
                op.code = OP_CRCB;
            end else begin
                n_done = 1'b1;
                if (i_in_data.rx_byte != ETX_BYTE || !i_in_data.chunk_end) begin
                    op.code = OP_FRAMING;
                end else begin
                    op.code = OP_END;
                end
            end
        end
        op.length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_len  <= '0;
            r_done <= 1'b0;
        end else if (accept) begin
            r_cnt  <= n_cnt;
            r_len  <= n_len;
            r_done <= n_done;
        end
    end

    assign o_push = accept;
    assign o_op   = op;

    a_ignore_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && accept && !i_in_data.start_frame) |-> (op.code == OP_IGNORE))
        else $error("byte after finished frame not ignored");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} <= MAX_BYTES_W))
        else $error("byte count beyond frame limit");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.start_frame && i_in_data.rx_byte == STX_BYTE)
            |=> (r_cnt == 9'd1 && r_len == 8'd0 && !r_done))
        else $error("start byte did not open a frame");

endmodule

// ===== sv/scfr_queue.sv =====
module scfr_queue
    import scfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_op  o_op
);

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_op       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/scfr_back.sv =====
module scfr_back
    import scfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_crc_seed,
    input  logic        i_nonempty,
    input  t_op         i_op,
    output logic        o_pop,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out        o_out_data
);

    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rcv, n_rcv;
    logic        r_valid;
    t_out        r_out, n_out;
    logic        pop;

    assign pop = i_nonempty && (!r_valid || !i_out_stall);

    always_comb begin
        n_crc                = r_crc;
        n_rcv                = r_rcv;
        n_out.status         = ST_PENDING;
        n_out.payload_byte   = 8'd0;
        n_out.payload_valid  = 1'b0;
        n_out.payload_index  = 8'd0;
        n_out.payload_length = i_op.length;
        unique case (i_op.code)
            OP_IGNORE:  n_out.status = ST_IGNORED;
            OP_LOAD: begin
                n_crc = i_crc_seed;
                n_rcv = 16'd0;
            end
            OP_FRAMING: n_out.status = ST_FRAMING;
            OP_PAYLOAD: begin
                n_crc               = crc16_step(r_crc, i_op.data);
                n_out.payload_byte  = i_op.data;
                n_out.payload_valid = 1'b1;
                n_out.payload_index = i_op.index;
            end
            OP_CRCB:    n_rcv = {r_rcv[7:0], i_op.data};
            OP_END:     n_out.status = (r_rcv == r_crc) ? ST_GOOD : ST_CRC;
            default:    n_out.status = ST_PENDING;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_crc   <= 16'd0;
            r_rcv   <= 16'd0;
        end else begin
            if (pop) begin
                r_valid <= 1'b1;
                r_crc   <= n_crc;
                r_rcv   <= n_rcv;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_pop       = pop;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    a_payload_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.payload_valid) |-> (r_out.status == ST_PENDING))
        else $error("payload byte carries a final status");

    a_crc_only_on_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_op.code != OP_PAYLOAD && i_op.code != OP_LOAD) |=> $stable(r_crc))
        else $error("crc changed outside payload");

    a_no_pop_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |-> !pop)
        else $error("result overwritten while held");

endmodule

// ===== sv/short_frame_receiver_crc_check.sv =====
// Short-frame receiver: checks a byte stream against STX, length (1..251), payload,
// big-endian CRC-16 (poly 0x1021, seeded from the config register, loaded at each start
// byte) and ETX, and returns one result per byte: status, payload byte/index and the
// current length. Throughput is one byte per clock unless the output stalls; output
// valid rises once the byte has been queued and registered. A front stage tracks
// framing and a back stage runs the CRC and final check; input stall rises only when
// the two-entry queue between them is full. Seed writes apply from the next start byte.
module short_frame_receiver_crc_check
    import scfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_crc_seed;
    logic        push;
    logic        pop;
    logic        full;
    logic        nonempty;
    t_op         op_in;
    t_op         op_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_seed <= 16'd0;
        end else if (i_cfg_valid) begin
            r_crc_seed <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;

    scfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_push     (push),
        .o_op       (op_in)
    );

    scfr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_op       (op_in),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_op       (op_out)
    );

    scfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_crc_seed  (r_crc_seed),
        .i_nonempty  (nonempty),
        .i_op        (op_out),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/tb_short_frame_receiver_crc_check.sv =====
module tb_short_frame_receiver_crc_check;
    timeunit 1ns;
    timeprecision 1ps;
    import scfr_pkg::*;

    localparam int IDLE_PCT       = 34;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_BYTES    = 1250;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_END,
        FR_EARLY_END,
        FR_BAD_START,
        FR_TRUNCATED
    } t_frame_kind;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    // receiver tracking state
    logic [15:0] crc_seed_val = '0;
    int          rx_count     = 0;
    logic [7:0]  rx_len       = '0;
    logic [15:0] crc_calc     = '0;
    logic [15:0] crc_got      = '0;
    bit          rx_done      = 1'b0;

    t_out        expected_status[$];
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          hold_cycles    = 0;
    int          quiet_cycles   = 0;
    bit          calm           = 1'b0;

    short_frame_receiver_crc_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ d[i];
            crc = {crc[14:0], 1'b0};
            if (fb) crc = crc ^ 16'h1021;
        end
        return crc;
    endfunction

    function automatic t_out frame_step(input t_in item);
        t_out r;
        int   n;
        int   b;
        r        = '0;
        r.status = ST_PENDING;
        b        = int'(item.rx_byte);
        if (item.start_frame) begin
            rx_count = 0;
            rx_len   = '0;
            crc_calc = crc_seed_val;
            crc_got  = '0;
            rx_done  = 1'b0;
        end
        if (rx_done) begin
            r.status = ST_IGNORED;
        end else if (rx_count == 0) begin
            if (item.rx_byte != STX_BYTE) begin
                r.status = ST_FRAMING;
                rx_done  = 1'b1;
            end else begin
                rx_count = 1;
                crc_calc = crc_seed_val;
                crc_got  = '0;
                rx_len   = '0;
            end
        end else if (rx_count >= MAX_FRAME_BYTES) begin
            r.status = ST_FRAMING;
            rx_done  = 1'b1;
        end else begin
            n        = rx_count + 1;
            rx_count = n;
            if (n == 2) begin
                rx_len = item.rx_byte;
                if (b < 1 || b + 5 > MAX_FRAME_BYTES) begin
                    r.status = ST_FRAMING;
                    rx_done  = 1'b1;
                end
            end else if (n <= int'(rx_len) + 2) begin
                crc_calc        = crc_byte(crc_calc, item.rx_byte);
                r.payload_byte  = item.rx_byte;
                r.payload_valid = 1'b1;
                r.payload_index = 8'(n - 3);
            end else if (n <= int'(rx_len) + 4) begin
                crc_got = {crc_got[7:0], item.rx_byte};
            end else begin
                rx_done = 1'b1;
                if (item.rx_byte != ETX_BYTE || !item.chunk_end)
                    r.status = ST_FRAMING;
                else if (crc_got != crc_calc)
                    r.status = ST_CRC;
                else
                    r.status = ST_GOOD;
            end
        end
        r.payload_length = rx_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (expected_status.size() == 0) begin
            report_mismatch("unexpected transfer, status", int'(got.status), 0);
            return;
        end
        want = expected_status.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
        if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", int'(got.payload_byte),
                            int'(want.payload_byte));
        if (got.payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", int'(got.payload_valid),
                            int'(want.payload_valid));
        if (got.payload_index !== want.payload_index)
            report_mismatch("payload_index", int'(got.payload_index),
                            int'(want.payload_index));
        if (got.payload_length !== want.payload_length)
            report_mismatch("payload_length", int'(got.payload_length),
                            int'(want.payload_length));
    endtask

    // output side: check, random stall, long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sf, input logic ce);
        t_in item;
        item.rx_byte     = b;
        item.start_frame = sf;
        item.chunk_end   = ce;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        expected_status.push_back(frame_step(item));
        bytes_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [15:0] value);
        wait_drained();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        crc_seed_val = value;
    endtask

    function automatic logic [7:0] pick_not(input logic [7:0] x);
        logic [7:0] v;
        v = 8'($urandom);
        if (v == x) v = ~x;
        return v;
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 90) return $urandom_range(9, 40);
        if (r < 96) return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(252, 255);
        return $urandom_range(200, 251);
    endfunction

    // fill < 0 gives random payload bytes
    task automatic send_frame(input t_frame_kind kind, input int len, input int fill);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        logic [7:0]  b;
        int          stop;
        crc = crc_seed_val;
        frame_q.push_back((kind == FR_BAD_START) ? pick_not(STX_BYTE) : STX_BYTE);
        frame_q.push_back(8'(len));
        if (kind != FR_BAD_START && len >= 1 && len + 5 <= MAX_FRAME_BYTES) begin
            for (int i = 0; i < len; i++) begin
                b   = (fill < 0) ? 8'($urandom) : 8'(fill);
                crc = crc_byte(crc, b);
                frame_q.push_back(b);
            end
            if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
            frame_q.push_back(crc[15:8]);
            frame_q.push_back(crc[7:0]);
            frame_q.push_back((kind == FR_BAD_END) ? pick_not(ETX_BYTE) : ETX_BYTE);
        end
        stop = frame_q.size();
        if (kind == FR_BAD_START) stop = 1;
        if (kind == FR_TRUNCATED) stop = $urandom_range(1, frame_q.size() - 1);
        for (int i = 0; i < stop; i++) begin
            send_byte(frame_q[i], i == 0,
                      (i == frame_q.size() - 1) ? (kind != FR_EARLY_END)
                                                : ($urandom_range(0, 3) == 0));
        end
    endtask

    task automatic test_directed();
        send_frame(FR_GOOD, 1, 8'h00);
        send_byte(8'hFF, 1'b1, 1'b1);          // bad start
        send_byte(8'hAA, 1'b0, 1'b0);          // ignored after error
        send_frame(FR_GOOD, 0, -1);            // zero length
        send_frame(FR_GOOD, 255, -1);          // oversize length
        send_frame(FR_BAD_CRC, 1, 8'hFF);
        send_byte(STX_BYTE, 1'b1, 1'b0);       // frame opened here is cleared mid-frame by the next start
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        send_frame(FR_GOOD, 1, 8'h5A);
        send_frame(FR_EARLY_END, 1, -1);
    endtask

    task automatic test_seed_extremes();
        logic [15:0] seeds[4];
        seeds = '{16'hFFFF, 16'h0000, 16'h1D0F, 16'($urandom)};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_frame(FR_GOOD, $urandom_range(1, 8), -1);
            send_frame(FR_BAD_CRC, $urandom_range(1, 8), -1);
            send_frame(FR_GOOD, $urandom_range(1, 16), -1);
            send_frame(FR_BAD_END, $urandom_range(1, 4), -1);
        end
    endtask

    task automatic test_max_length();
        write_seed(16'($urandom));
        send_frame(FR_GOOD, 251, -1);
        send_frame(FR_BAD_CRC, 251, -1);
        send_frame(FR_GOOD, 252, -1);
    endtask

    task automatic test_no_idle();
        int start_count;
        start_count = bytes_sent;
        calm        = 1'b1;
        while (bytes_sent - start_count < 150)
            send_frame(($urandom_range(0, 3) == 0) ? FR_BAD_CRC : FR_GOOD,
                       $urandom_range(1, 16), -1);
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (6) send_frame(FR_GOOD, $urandom_range(1, 12), -1);
    endtask

    task automatic test_random_traffic();
        int          r;
        t_frame_kind kind;
        while (bytes_sent < TOTAL_BYTES) begin
            if ($urandom_range(0, 39) == 0) write_seed(16'($urandom));
            r = $urandom_range(0, 99);
            if (r < 92) begin
                if (r < 50)      kind = FR_GOOD;
                else if (r < 62) kind = FR_BAD_CRC;
                else if (r < 70) kind = FR_BAD_END;
                else if (r < 78) kind = FR_EARLY_END;
                else if (r < 84) kind = FR_BAD_START;
                else             kind = FR_TRUNCATED;
                send_frame(kind, pick_length(), -1);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 1) != 0);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom), 1'b0, $urandom_range(0, 1) != 0);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_seed_extremes();
        test_max_length();
        test_no_idle();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
